// File: rtl/crt_pkg.sv
// Package for the chunk reassembly tracker: field layouts, status codes,
// register indexes and reset values. Used by every file under rtl/.
`default_nettype none
package crt_pkg;

    localparam int HEADER_BYTES   = 24;
    localparam int MAX_CHUNKS_DEF = 4096;
    localparam int WORD_BITS      = 32;
    localparam int BIT_W          = 5;

    localparam logic [31:0] MAGIC_RESET      = 32'h4654_5531;
    localparam logic [15:0] CHUNK_SIZE_RESET = 16'd1200;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 1'b1;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_OVER_CAP   = 3'd3;
    localparam logic [2:0] ST_AFTER_DONE = 3'd4;

    // Declared high field first, so that the first field sits in the low bits.
    typedef struct packed {
        logic [63:0] file_bytes;
        logic [31:0] payload_len;
        logic [31:0] chunk_total;
        logic [31:0] seq_num;
        logic [31:0] magic;
        logic [16:0] datagram_len;
    } in_item_t;

    typedef struct packed {
        logic        done_res;
        logic [27:0] bytes_received;
        logic [12:0] chunks_received;
        logic [63:0] expected_size;
        logic        first_chunk;
        logic [15:0] write_length;
        logic [27:0] write_offset;
        logic [2:0]  status;
    } out_item_t;

    localparam int IN_BITS    = $bits(in_item_t);
    localparam int OUT_BITS   = $bits(out_item_t);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] chunk_size;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/crt_cfg.sv
// Configuration registers of the chunk reassembly tracker.
// Depends on crt_pkg for register indexes and reset values.
`default_nettype none
module crt_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_data,
    output crt_pkg::cfg_t                       cfg
);

    crt_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word <= crt_pkg::MAGIC_RESET;
            cfg_reg.chunk_size <= crt_pkg::CHUNK_SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                crt_pkg::CFG_MAGIC_WORD: cfg_reg.magic_word <= cfg_data;
                crt_pkg::CFG_CHUNK_SIZE: cfg_reg.chunk_size <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/crt_bitmap.sv
// Received-chunk bitmap: a memory of 32-bit rows with a registered read,
// forwarding of the newest row write, and a clearing pass after reset.
// Depends on crt_pkg for the row width.
`default_nettype none
module crt_bitmap #(
    parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF,
    localparam int ROWS  = (MAX_CHUNKS + crt_pkg::WORD_BITS - 1) / crt_pkg::WORD_BITS,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rd_en,
    input  wire logic [ROW_W-1:0]              rd_row,
    input  wire logic                          wr_en,
    input  wire logic [ROW_W-1:0]              wr_row,
    input  wire logic [crt_pkg::WORD_BITS-1:0] wr_word,
    output logic [crt_pkg::WORD_BITS-1:0]      row_word,
    output logic                               busy
);

    logic [crt_pkg::WORD_BITS-1:0] mem [0:ROWS-1];

    logic [crt_pkg::WORD_BITS-1:0] rd_data_reg;
    logic [ROW_W-1:0]              rd_row_reg;
    logic                          lw_valid_reg;
    logic [ROW_W-1:0]              lw_row_reg;
    logic [crt_pkg::WORD_BITS-1:0] lw_word_reg;
    logic                          clr_busy_reg;
    logic [ROW_W-1:0]              clr_cnt_reg;

    assign busy = clr_busy_reg;

    // A row written at the same edge as the read returns stale data, so the
    // newest written row takes precedence over the memory output when its row matches.
    assign row_word = (lw_valid_reg && (lw_row_reg == rd_row_reg)) ? lw_word_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
            rd_row_reg  <= rd_row;
        end
        if (wr_en) begin
            mem[wr_row] <= wr_word;
        end else if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end
        if (wr_en) begin
            lw_row_reg  <= wr_row;
            lw_word_reg <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                if (clr_cnt_reg == ROW_W'(ROWS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
            end
            if (wr_en) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    a_no_access_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> (!wr_en && !rd_en))
        else $error("bitmap accessed during clearing pass");

    a_clear_ends_on_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (clr_busy_reg && (clr_cnt_reg == ROW_W'(ROWS - 1))) |=> !clr_busy_reg)
        else $error("clearing pass did not end after the last row");

    a_forward_tracks_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (lw_valid_reg && (lw_row_reg == $past(wr_row))))
        else $error("forwarding register missed a row write");

endmodule
`default_nettype wire

// File: rtl/chunk_reassembly_tracker.sv
// Chunk reassembly tracker: one header word in, one status word out. A word is
// held in the input register and its result in the output register, so the
// block sustains one word every cycle while m_axis_tready is high; the chunk
// bitmap row is read when the word is taken and written back when its result
// is registered, with the newest row forwarded. After reset the bitmap is swept
// clear, one 32-bit row a cycle over (MAX_CHUNKS+31)/32 rows (128 by default),
// while s_axis_tready stays low; configuration writes are taken throughout.
`default_nettype none
module chunk_reassembly_tracker #(
    parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // tdata, low bit up: datagram_len, magic, seq_num, chunk_total,
    // payload_len, file_bytes, zero fill.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [crt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tdata, low bit up: status, write_offset, write_length, first_chunk,
    // expected_size, chunks_received, bytes_received, done_res, zero fill.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [crt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [crt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    localparam int ROWS  = (MAX_CHUNKS + crt_pkg::WORD_BITS - 1) / crt_pkg::WORD_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int BW    = crt_pkg::BIT_W;

    crt_pkg::cfg_t     cfg;
    crt_pkg::in_item_t s_item;
    crt_pkg::in_item_t in_reg;
    crt_pkg::out_item_t out_reg;
    crt_pkg::out_item_t out_next;

    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic take_in;

    logic             started_reg;
    logic [31:0]      latched_total_reg;
    logic [63:0]      latched_size_reg;
    logic [CNT_W-1:0] accepted_count_reg;
    logic [27:0]      byte_count_reg;
    logic             finished_reg;

    logic [CNT_W-1:0] accepted_count_next;
    logic [27:0]      byte_count_next;
    logic             finished_next;

    logic [ROW_W-1:0]              cur_row;
    logic [BW-1:0]                 cur_bit;
    logic [crt_pkg::WORD_BITS-1:0] row_word;
    logic                          bm_busy;

    logic        hdr_bad;
    logic        over_cap;
    logic        dup;
    logic        ok_hdr;
    logic        accept;
    logic        latch;
    logic [31:0] total_eff;
    logic [31:0] cnt_ext;
    logic [28:0] byte_sum;
    logic [43:0] offset_prod;

    crt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_item  = crt_pkg::in_item_t'(s_axis_tdata[crt_pkg::IN_BITS-1:0]);
    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !bm_busy && (!in_valid_reg || advance);
    assign take_in = s_axis_tvalid && s_axis_tready;

    assign cur_row = in_reg.seq_num[BW+ROW_W-1:BW];
    assign cur_bit = in_reg.seq_num[BW-1:0];

    crt_bitmap #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_bitmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (take_in),
        .rd_row   (s_item.seq_num[BW+ROW_W-1:BW]),
        .wr_en    (advance && accept),
        .wr_row   (cur_row),
        .wr_word  (row_word | (crt_pkg::WORD_BITS'(1) << cur_bit)),
        .row_word (row_word),
        .busy     (bm_busy)
    );

    always_comb begin
        hdr_bad = (in_reg.datagram_len < 17'(crt_pkg::HEADER_BYTES))
               || (in_reg.magic != cfg.magic_word)
               || (({1'b0, in_reg.payload_len} + 33'(crt_pkg::HEADER_BYTES))
                   != {16'd0, in_reg.datagram_len})
               || (in_reg.seq_num >= in_reg.chunk_total)
               || (in_reg.payload_len[31:16] != 16'd0)
               || (started_reg && (in_reg.seq_num >= latched_total_reg));
        over_cap  = in_reg.seq_num >= 32'(MAX_CHUNKS);
        ok_hdr    = !finished_reg && !hdr_bad && !over_cap;
        // A bit can only be set once the first chunk has latched the totals.
        dup       = row_word[cur_bit];
        latch     = ok_hdr && !started_reg;
        accept    = ok_hdr && !dup;
        total_eff = started_reg ? latched_total_reg : in_reg.chunk_total;

        accepted_count_next = accepted_count_reg;
        byte_count_next     = byte_count_reg;
        finished_next       = finished_reg;
        byte_sum    = {1'b0, byte_count_reg} + {13'd0, in_reg.payload_len[15:0]};
        offset_prod = in_reg.seq_num[27:0] * cfg.chunk_size;
        if (accept) begin
            accepted_count_next = accepted_count_reg + CNT_W'(1);
            byte_count_next     = byte_sum[28] ? 28'hFFF_FFFF : byte_sum[27:0];
            finished_next       = 32'(accepted_count_next) == total_eff;
        end
        cnt_ext = 32'(accepted_count_next);

        out_next.status          = crt_pkg::ST_ACCEPTED;
        out_next.write_offset    = '0;
        out_next.write_length    = '0;
        out_next.first_chunk     = latch && accept;
        out_next.expected_size   = latch ? in_reg.file_bytes : latched_size_reg;
        out_next.chunks_received = cnt_ext[12:0];
        out_next.bytes_received  = byte_count_next;
        out_next.done_res        = finished_next;
        priority if (finished_reg) begin
            out_next.status = crt_pkg::ST_AFTER_DONE;
        end else if (hdr_bad) begin
            out_next.status = crt_pkg::ST_BAD_HEADER;
        end else if (over_cap) begin
            out_next.status = crt_pkg::ST_OVER_CAP;
        end else if (dup) begin
            out_next.status = crt_pkg::ST_DUPLICATE;
        end else begin
            out_next.write_offset = offset_prod[27:0];
            out_next.write_length = in_reg.payload_len[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
        if (advance && latch) begin
            latched_total_reg <= in_reg.chunk_total;
            latched_size_reg  <= in_reg.file_bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            started_reg        <= 1'b0;
            accepted_count_reg <= '0;
            byte_count_reg     <= '0;
            finished_reg       <= 1'b0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                started_reg        <= started_reg || latch;
                accepted_count_reg <= accepted_count_next;
                byte_count_reg     <= byte_count_next;
                finished_reg       <= finished_next;
            end
        end
    end

    // The latched size and total are held in payload registers; before the
    // first chunk the expected size reads as zero through the started flag.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = crt_pkg::OUT_TDATA_W'({out_reg.done_res, out_reg.bytes_received,
                           out_reg.chunks_received,
                           started_reg || out_reg.first_chunk ? out_reg.expected_size : 64'd0,
                           out_reg.first_chunk, out_reg.write_length,
                           out_reg.write_offset, out_reg.status});

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("done flag dropped");

    a_no_input_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_busy |-> !s_axis_tready)
        else $error("input taken during bitmap clearing");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(accepted_count_reg) <= 32'(MAX_CHUNKS))
        else $error("accepted chunk count beyond bitmap capacity");

    a_write_only_when_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.status != crt_pkg::ST_ACCEPTED))
        |-> ((out_reg.write_offset == 28'd0) && (out_reg.write_length == 16'd0)))
        else $error("write fields set on a rejected word");

endmodule
`default_nettype wire
